FILE: rtl/core/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg
// shared constants and codes for the order book level block
// ----------------------------------------------------------------------------
package lob_pkg;

	localparam int ORDER_SLOTS_DEF = 256;
	localparam int MAX_LEVELS_DEF  = 16;

	// field widths
	localparam int ID_W   = 32;
	localparam int PX_W   = 32;
	localparam int QTY_W  = 32;
	localparam int SUM_W  = 40;
	localparam int CNT_W  = 9;
	localparam int SPR_W  = 33;
	localparam int SLOT_W = ID_W + 1 + PX_W + QTY_W;

	// operations
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_SNAP   = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_BOOK   = 2'd0;
	localparam logic [1:0] KIND_LEVEL  = 2'd1;
	localparam logic [1:0] KIND_MARKER = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_NOT_LIMIT = 3'd2;
	localparam logic [2:0] ST_NO_PRICE  = 3'd3;
	localparam logic [2:0] ST_DUP_ID    = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

endpackage

FILE: rtl/core/limit_order_book_levels.sv
// ----------------------------------------------------------------------------
// limit_order_book_levels
// resting order table with best price report and aggregated depth levels
// ----------------------------------------------------------------------------
// add and cancel take one pass over all slots from start to result strobe,
// busy for that whole time
// a snapshot takes one pass per emitted level plus one closing pass per side
// that runs short, so at most 2 * levels passes, then a closing step for
// the last result; the single slot ram read port sets the pace, one item in
// flight at a time
// results are strobed for one cycle each, the receiver cannot stall
// reset empties the book at once (slot used bits in flops), ram is left as is
module limit_order_book_levels #(
	parameter int ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
	parameter int MAX_LEVELS  = lob_pkg::MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] order_ref,
	input  logic        is_buy,
	input  logic        is_limit,
	input  logic        has_price,
	input  logic [31:0] price,
	input  logic [31:0] quantity,
	input  logic [4:0]  snapshot_levels,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  status,
	output logic        bid_valid,
	output logic [31:0] top_bid,
	output logic        ask_valid,
	output logic [31:0] top_ask,
	output logic signed [32:0] spread,
	output logic        level_side,
	output logic [31:0] level_price,
	output logic [39:0] level_quantity,
	output logic [8:0]  level_orders,
	output logic        last
);

	localparam int AW = $clog2(ORDER_SLOTS);
	localparam int LW = $clog2(MAX_LEVELS + 1);
	localparam int SW = lob_pkg::SLOT_W;
	localparam logic [AW-1:0] LAST_SLOT = AW'(ORDER_SLOTS - 1);
	localparam logic [5:0]    MAXL6     = 6'(MAX_LEVELS);

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [1:0] S_ENDS = 2'd3;

	logic [1:0] state_q;

	// latched item
	logic [1:0]  op_q;
	logic [31:0] id_q, price_q, qty_q;
	logic        buy_q, limit_q, hasp_q;
	logic [LW-1:0] lim_q;

	// scan pipeline
	logic [AW-1:0] addr_q;
	logic          iss_q;
	logic          vld_s1, last_s1, used_s1;
	logic [AW-1:0] idx_s1;
	logic [ORDER_SLOTS-1:0] used_q;

	// ram
	logic          we;
	logic [SW-1:0] wdata, rdata;
	logic [31:0]   d_id, d_px, d_qty;
	logic          d_buy;

	// pass accumulators
	logic          dup_q, free_q, match_q;
	logic [AW-1:0] free_idx_q, match_idx_q;
	logic          bv_q, av_q;
	logic [31:0]   bb_q, ba_q;
	logic          fnd_q;
	logic [31:0]   p_q;
	logic [39:0]   sum_q;
	logic [8:0]    cnt_q;

	// snapshot walk
	logic          side_q, have_prev_q;
	logic [31:0]   prev_q;
	logic [LW-1:0] lvl_q;
	logic          pend_q, pend_side_q;
	logic [31:0]   pend_px_q;
	logic [39:0]   pend_sum_q;
	logic [8:0]    pend_cnt_q;

	// final book view for add and cancel
	logic [2:0]  add_st, book_st;
	logic        fbv, fav;
	logic [31:0] fbb, fba;
	logic [5:0]  lim6;
	logic        skip_px, better;

	assign {d_id, d_buy, d_px, d_qty} = rdata;
	assign we    = (state_q == S_FIN) && (op_q == lob_pkg::OP_ADD) && (add_st == lob_pkg::ST_OK);
	assign wdata = {id_q, buy_q, price_q, qty_q};
	assign busy  = (state_q != S_IDLE);

	lob_ram #(
		.WIDTH(SW),
		.DEPTH(ORDER_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(free_idx_q),
		.wdata(wdata),
		.raddr(addr_q),
		.rdata(rdata)
	);

	// level count clipped to 1..MAX_LEVELS
	always_comb begin
		lim6 = {1'b0, snapshot_levels};
		if (lim6 == 6'd0) begin
			lim6 = 6'd1;
		end
		if (lim6 > MAXL6) begin
			lim6 = MAXL6;
		end
	end

	// add status by priority, book status for add or cancel, then fold the new order into the best prices
	always_comb begin
		priority if (!limit_q) add_st = lob_pkg::ST_NOT_LIMIT;
		else if (!hasp_q)      add_st = lob_pkg::ST_NO_PRICE;
		else if (dup_q)        add_st = lob_pkg::ST_DUP_ID;
		else if (!free_q)      add_st = lob_pkg::ST_FULL;
		else                   add_st = lob_pkg::ST_OK;
		book_st = (op_q == lob_pkg::OP_ADD) ? add_st :
			(match_q ? lob_pkg::ST_OK : lob_pkg::ST_NOT_FOUND);
		fbv = bv_q;
		fbb = bb_q;
		fav = av_q;
		fba = ba_q;
		if (op_q == lob_pkg::OP_ADD && add_st == lob_pkg::ST_OK) begin
			if (buy_q) begin
				if (!bv_q || price_q > bb_q) begin
					fbv = 1'b1;
					fbb = price_q;
				end
			end else begin
				if (!av_q || price_q < ba_q) begin
					fav = 1'b1;
					fba = price_q;
				end
			end
		end
	end

	// snapshot candidate filter and compare for the slot in stage 1
	always_comb begin
		skip_px = have_prev_q && (side_q ? (d_px >= prev_q) : (d_px <= prev_q));
		better  = !fnd_q || (side_q ? (d_px > p_q) : (d_px < p_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			last_s1     <= 1'b0;
			used_s1     <= 1'b0;
			idx_s1      <= '0;
			addr_q      <= '0;
			strobe      <= 1'b0;
			op_q        <= '0;
			id_q        <= '0;
			price_q     <= '0;
			qty_q       <= '0;
			buy_q       <= 1'b0;
			limit_q     <= 1'b0;
			hasp_q      <= 1'b0;
			lim_q       <= '0;
			dup_q       <= 1'b0;
			free_q      <= 1'b0;
			match_q     <= 1'b0;
			free_idx_q  <= '0;
			match_idx_q <= '0;
			bv_q        <= 1'b0;
			av_q        <= 1'b0;
			bb_q        <= '0;
			ba_q        <= '0;
			fnd_q       <= 1'b0;
			p_q         <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			side_q      <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			lvl_q       <= '0;
			pend_q      <= 1'b0;
			pend_side_q <= 1'b0;
			pend_px_q   <= '0;
			pend_sum_q  <= '0;
			pend_cnt_q  <= '0;
			kind        <= '0;
			status      <= '0;
			bid_valid   <= 1'b0;
			top_bid     <= '0;
			ask_valid   <= 1'b0;
			top_ask     <= '0;
			spread      <= '0;
			level_side  <= 1'b0;
			level_price <= '0;
			level_quantity <= '0;
			level_orders   <= '0;
			last        <= 1'b0;
		end else begin
			strobe <= 1'b0;

			// read issue side of the scan
			vld_s1  <= iss_q;
			last_s1 <= (addr_q == LAST_SLOT);
			used_s1 <= used_q[addr_q];
			idx_s1  <= addr_q;
			if (iss_q) begin
				if (addr_q == LAST_SLOT) begin
					iss_q <= 1'b0;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (start && operation != 2'd3) begin
						op_q    <= operation;
						id_q    <= order_ref;
						buy_q   <= is_buy;
						limit_q <= is_limit;
						hasp_q  <= has_price;
						price_q <= price;
						qty_q   <= quantity;
						lim_q   <= LW'(lim6);
						side_q  <= 1'b1;
						have_prev_q <= 1'b0;
						lvl_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_SCAN;
						addr_q  <= '0;
						iss_q   <= 1'b1;
						dup_q   <= 1'b0;
						free_q  <= 1'b0;
						match_q <= 1'b0;
						bv_q    <= 1'b0;
						av_q    <= 1'b0;
						bb_q    <= '0;
						ba_q    <= '0;
						fnd_q   <= 1'b0;
					end
				end

				S_SCAN: begin
					if (vld_s1) begin
						unique case (op_q)
							lob_pkg::OP_ADD: begin
								if (used_s1) begin
									if (d_id == id_q) begin
										dup_q <= 1'b1;
									end
								end else if (!free_q) begin
									free_q     <= 1'b1;
									free_idx_q <= idx_s1;
								end
							end
							lob_pkg::OP_CANCEL: begin
								if (used_s1 && !match_q && d_id == id_q) begin
									match_q     <= 1'b1;
									match_idx_q <= idx_s1;
								end
							end
							default: begin
								if (used_s1 && d_buy == side_q && !skip_px) begin
									if (better) begin
										fnd_q <= 1'b1;
										p_q   <= d_px;
										sum_q <= {8'd0, d_qty};
										cnt_q <= 9'd1;
									end else if (d_px == p_q) begin
										sum_q <= sum_q + {8'd0, d_qty};
										cnt_q <= cnt_q + 9'd1;
									end
								end
							end
						endcase
						// best prices, leaving out the slot a cancel removes
						if (op_q != lob_pkg::OP_SNAP && used_s1 &&
							!(op_q == lob_pkg::OP_CANCEL && !match_q && d_id == id_q)) begin
							if (d_buy) begin
								if (!bv_q || d_px > bb_q) begin
									bv_q <= 1'b1;
									bb_q <= d_px;
								end
							end else begin
								if (!av_q || d_px < ba_q) begin
									av_q <= 1'b1;
									ba_q <= d_px;
								end
							end
						end
						if (last_s1) begin
							state_q <= S_FIN;
						end
					end
				end

				S_FIN: begin
					if (op_q != lob_pkg::OP_SNAP) begin
						// book result for add or cancel
						if (op_q == lob_pkg::OP_ADD && add_st == lob_pkg::ST_OK) begin
							used_q[free_idx_q] <= 1'b1;
						end
						if (op_q == lob_pkg::OP_CANCEL && match_q) begin
							used_q[match_idx_q] <= 1'b0;
						end
						strobe      <= 1'b1;
						kind        <= lob_pkg::KIND_BOOK;
						status      <= book_st;
						bid_valid   <= fbv;
						top_bid     <= fbb;
						ask_valid   <= fav;
						top_ask     <= fba;
						spread      <= (fbv && fav) ? ({1'b0, fba} - {1'b0, fbb}) : '0;
						level_side  <= 1'b0;
						level_price <= '0;
						level_quantity <= '0;
						level_orders   <= '0;
						last        <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						// level found: send the one held back, hold this one
						if (fnd_q) begin
							if (pend_q) begin
								strobe      <= 1'b1;
								kind        <= lob_pkg::KIND_LEVEL;
								status      <= lob_pkg::ST_OK;
								bid_valid   <= 1'b0;
								top_bid     <= '0;
								ask_valid   <= 1'b0;
								top_ask     <= '0;
								spread      <= '0;
								level_side  <= pend_side_q;
								level_price <= pend_px_q;
								level_quantity <= pend_sum_q;
								level_orders   <= pend_cnt_q;
								last        <= 1'b0;
							end
							pend_q      <= 1'b1;
							pend_side_q <= side_q;
							pend_px_q   <= p_q;
							pend_sum_q  <= sum_q;
							pend_cnt_q  <= cnt_q;
						end
						fnd_q <= 1'b0;
						if (fnd_q && (lvl_q + 1'b1) != lim_q) begin
							// next level of this side has a worse price than the one just found
							prev_q      <= p_q;
							have_prev_q <= 1'b1;
							lvl_q   <= lvl_q + 1'b1;
							state_q <= S_SCAN;
							addr_q  <= '0;
							iss_q   <= 1'b1;
						end else if (side_q) begin
							// bids done, walk the asks
							side_q      <= 1'b0;
							have_prev_q <= 1'b0;
							lvl_q       <= '0;
							state_q     <= S_SCAN;
							addr_q      <= '0;
							iss_q       <= 1'b1;
						end else begin
							state_q <= S_ENDS;
						end
					end
				end

				S_ENDS: begin
					// final level, or the empty book marker
					strobe      <= 1'b1;
					kind        <= pend_q ? lob_pkg::KIND_LEVEL : lob_pkg::KIND_MARKER;
					status      <= lob_pkg::ST_OK;
					bid_valid   <= 1'b0;
					top_bid     <= '0;
					ask_valid   <= 1'b0;
					top_ask     <= '0;
					spread      <= '0;
					level_side  <= pend_q & pend_side_q;
					level_price <= pend_q ? pend_px_q : '0;
					level_quantity <= pend_q ? pend_sum_q : '0;
					level_orders   <= pend_q ? pend_cnt_q : '0;
					last        <= 1'b1;
					state_q     <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// read data only arrives during a scan
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_SCAN))
		else $error("slot read returned outside a scan");

	// a result transfer follows only a finishing step
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == S_FIN || $past(state_q) == S_ENDS))
		else $error("result strobe without a finishing step");

	// add and cancel results and the empty marker close their item
	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind != lob_pkg::KIND_LEVEL) |-> (last && !busy))
		else $error("single result not marked last");

	// the ram is written only while no read pass is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (!iss_q && !vld_s1))
		else $error("slot write overlaps a scan");

endmodule

FILE: rtl/core/lob_ram.sv
// ----------------------------------------------------------------------------
// lob_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module lob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: verif/limit_order_book_levels_test.sv
// ----------------------------------------------------------------------------
// limit_order_book_levels_test
// self-checking bench for the order book level block: a directed table of
// add, cancel and snapshot commands, then random traffic with a book fill,
// each result checked against typed-in values or a behavioural book model kept in the bench
// ----------------------------------------------------------------------------
module limit_order_book_levels_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  SLOTS      = lob_pkg::ORDER_SLOTS_DEF;
	localparam int  LEVELS     = lob_pkg::MAX_LEVELS_DEF;
	localparam int  RUN_LIMIT  = 15_000_000;
	// longest quiet stretch after the last result: a snapshot of a full book
	localparam int  DRAIN_WAIT = 2 * (LEVELS + 1) * (SLOTS + 2) + 64;
	localparam logic [1:0] OP_NONE = 2'd3;

	// one command as the sender presents it
	typedef struct {
		logic [1:0]  op;
		logic [31:0] id;
		logic        buy;
		logic        lim;
		logic        hp;
		logic [31:0] px;
		logic [31:0] qty;
		logic [4:0]  lv;
		logic        typed;   // expected result typed in below, not predicted
		logic [1:0]  t_kind;
		logic [2:0]  t_status;
	} cmd_t;

	// one result as the block strobes it
	typedef struct {
		logic [1:0]         kind;
		logic [2:0]         status;
		logic               bid_valid;
		logic [31:0]        top_bid;
		logic               ask_valid;
		logic [31:0]        top_ask;
		logic signed [32:0] spread;
		logic               level_side;
		logic [31:0]        level_price;
		logic [39:0]        level_quantity;
		logic [8:0]         level_orders;
		logic               last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0]  operation;
	logic [31:0] order_ref;
	logic        is_buy;
	logic        is_limit;
	logic        has_price;
	logic [31:0] price;
	logic [31:0] quantity;
	logic [4:0]  snapshot_levels;
	logic        strobe;
	logic [1:0]  kind;
	logic [2:0]  status;
	logic        bid_valid;
	logic [31:0] top_bid;
	logic        ask_valid;
	logic [31:0] top_ask;
	logic signed [32:0] spread;
	logic        level_side;
	logic [31:0] level_price;
	logic [39:0] level_quantity;
	logic [8:0]  level_orders;
	logic        last;

	// bench copy of the order table
	logic        book_used [SLOTS];
	logic [31:0] book_id   [SLOTS];
	logic        book_buy  [SLOTS];
	logic [31:0] book_px   [SLOTS];
	logic [31:0] book_qty  [SLOTS];

	res_t pending_results[$];
	int   error_count = 0;
	int   idle_pct    = 0;
	int   cycle_count = 0;

	always #6 clk = ~clk;

	limit_order_book_levels u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .order_ref(order_ref), .is_buy(is_buy),
		.is_limit(is_limit), .has_price(has_price), .price(price),
		.quantity(quantity), .snapshot_levels(snapshot_levels),
		.strobe(strobe), .kind(kind), .status(status),
		.bid_valid(bid_valid), .top_bid(top_bid), .ask_valid(ask_valid),
		.top_ask(top_ask), .spread(spread), .level_side(level_side),
		.level_price(level_price), .level_quantity(level_quantity),
		.level_orders(level_orders), .last(last)
	);

	// runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("limit_order_book_levels_test: done, errors");
			$finish;
		end
	end

	function automatic int live_orders();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++)
			if (book_used[i]) n++;
		return n;
	endfunction

	// best bid, best ask and spread after an add or cancel
	function automatic res_t book_top(logic [2:0] st);
		res_t r;
		r = '{default: '0};
		r.kind = lob_pkg::KIND_BOOK;
		r.status = st;
		for (int i = 0; i < SLOTS; i++) begin
			if (!book_used[i]) continue;
			if (book_buy[i]) begin
				if (!r.bid_valid || book_px[i] > r.top_bid) begin
					r.bid_valid = 1'b1;
					r.top_bid = book_px[i];
				end
			end else if (!r.ask_valid || book_px[i] < r.top_ask) begin
				r.ask_valid = 1'b1;
				r.top_ask = book_px[i];
			end
		end
		if (r.bid_valid && r.ask_valid)
			r.spread = {1'b0, r.top_ask} - {1'b0, r.top_bid};
		r.last = 1'b1;
		return r;
	endfunction

	// depth levels of one side, best price first
	task automatic add_side_levels(input logic buy, input int lim, ref res_t lv_q[$]);
		logic        have_prev;
		logic [31:0] prev;
		logic        found;
		logic [31:0] p;
		res_t        r;
		have_prev = 1'b0;
		prev = '0;
		for (int lv = 0; lv < lim; lv++) begin
			found = 1'b0;
			p = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (!book_used[i] || book_buy[i] != buy) continue;
				if (buy) begin
					if (have_prev && book_px[i] >= prev) continue;
					if (!found || book_px[i] > p) begin
						found = 1'b1;
						p = book_px[i];
					end
				end else begin
					if (have_prev && book_px[i] <= prev) continue;
					if (!found || book_px[i] < p) begin
						found = 1'b1;
						p = book_px[i];
					end
				end
			end
			if (!found) break;
			r = '{default: '0};
			r.kind = lob_pkg::KIND_LEVEL;
			r.level_side = buy;
			r.level_price = p;
			for (int i = 0; i < SLOTS; i++)
				if (book_used[i] && book_buy[i] == buy && book_px[i] == p) begin
					r.level_quantity = r.level_quantity + 40'(book_qty[i]);
					r.level_orders = r.level_orders + 9'd1;
				end
			lv_q = {lv_q, r};
			have_prev = 1'b1;
			prev = p;
		end
	endtask

	// apply one accepted command to the bench book and queue what it produces
	task automatic book_apply(input cmd_t c);
		res_t    out_q[$];
		res_t    r;
		logic [2:0] st;
		int      free_slot;
		int      lim;
		case (c.op)
			lob_pkg::OP_ADD: begin
				st = lob_pkg::ST_OK;
				free_slot = -1;
				if (!c.lim) st = lob_pkg::ST_NOT_LIMIT;
				else if (!c.hp) st = lob_pkg::ST_NO_PRICE;
				else begin
					for (int i = 0; i < SLOTS; i++)
						if (book_used[i]) begin
							if (book_id[i] == c.id) st = lob_pkg::ST_DUP_ID;
						end else if (free_slot < 0) free_slot = i;
					if (st == lob_pkg::ST_OK && free_slot < 0) st = lob_pkg::ST_FULL;
					if (st == lob_pkg::ST_OK) begin
						book_used[free_slot] = 1'b1;
						book_id[free_slot]   = c.id;
						book_buy[free_slot]  = c.buy;
						book_px[free_slot]   = c.px;
						book_qty[free_slot]  = c.qty;
					end
				end
				out_q = {out_q, book_top(st)};
			end
			lob_pkg::OP_CANCEL: begin
				st = lob_pkg::ST_NOT_FOUND;
				for (int i = 0; i < SLOTS; i++)
					if (book_used[i] && book_id[i] == c.id) begin
						book_used[i] = 1'b0;
						st = lob_pkg::ST_OK;
						break;
					end
				out_q = {out_q, book_top(st)};
			end
			lob_pkg::OP_SNAP: begin
				// level count clamped to 1..LEVELS
				lim = int'(c.lv);
				if (lim < 1) lim = 1;
				if (lim > LEVELS) lim = LEVELS;
				add_side_levels(1'b1, lim, out_q);
				add_side_levels(1'b0, lim, out_q);
				if (out_q.size() == 0) begin
					r = '{default: '0};
					r.kind = lob_pkg::KIND_MARKER;
					r.last = 1'b1;
					out_q = {out_q, r};
				end else out_q[out_q.size() - 1].last = 1'b1;
			end
			default: ;	// unused operation code: nothing happens, nothing comes back
		endcase
		if (c.typed) begin
			// typed-in rows stand on an empty book: everything but kind, status and last is zero
			r = '{default: '0};
			r.kind = c.t_kind;
			r.status = c.t_status;
			r.last = 1'b1;
			out_q = '{r};
		end
		pending_results = {pending_results, out_q};
	endtask

	// present one command, hold it until the transfer, then predict
	task automatic issue(input cmd_t c);
		int gap;
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 600) : $urandom_range(1, 30);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		operation       <= c.op;
		order_ref       <= c.id;
		is_buy          <= c.buy;
		is_limit        <= c.lim;
		has_price       <= c.hp;
		price           <= c.px;
		quantity        <= c.qty;
		snapshot_levels <= c.lv;
		start           <= 1'b1;
		do @(posedge clk); while (busy);
		book_apply(c);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// result side: every strobed result is taken at the edge that ends its cycle
	always @(posedge clk) begin
		res_t e;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$error("result strobed with nothing expected (kind %0d)", kind);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				check_field("kind", 64'(e.kind), 64'(kind));
				check_field("status", 64'(e.status), 64'(status));
				check_field("bid_valid", 64'(e.bid_valid), 64'(bid_valid));
				check_field("top_bid", 64'(e.top_bid), 64'(top_bid));
				check_field("ask_valid", 64'(e.ask_valid), 64'(ask_valid));
				check_field("top_ask", 64'(e.top_ask), 64'(top_ask));
				check_field("spread", 64'(unsigned'(e.spread)), 64'(unsigned'(spread)));
				check_field("level_side", 64'(e.level_side), 64'(level_side));
				check_field("level_price", 64'(e.level_price), 64'(level_price));
				check_field("level_quantity", 64'(e.level_quantity), 64'(level_quantity));
				check_field("level_orders", 64'(e.level_orders), 64'(level_orders));
				check_field("last", 64'(e.last), 64'(last));
			end
		end
	end

	function automatic cmd_t mk(logic [1:0] op, logic [31:0] id, logic buy, logic lim,
			logic hp, logic [31:0] px, logic [31:0] qty, logic [4:0] lv);
		cmd_t c;
		c = '{default: '0};
		c.op = op; c.id = id; c.buy = buy; c.lim = lim; c.hp = hp;
		c.px = px; c.qty = qty; c.lv = lv;
		return c;
	endfunction

	function automatic cmd_t mk_typed(cmd_t c, logic [1:0] k, logic [2:0] st);
		c.typed = 1'b1;
		c.t_kind = k;
		c.t_status = st;
		return c;
	endfunction

	// id of some resting order, or a random pool id when the book is empty
	function automatic logic [31:0] resting_id();
		int s;
		s = $urandom_range(0, SLOTS - 1);
		for (int i = 0; i < SLOTS; i++)
			if (book_used[(s + i) % SLOTS]) return book_id[(s + i) % SLOTS];
		return 32'($urandom_range(0, 63));
	endfunction

	function automatic cmd_t rand_add();
		cmd_t c;
		int   pick;
		c = mk(lob_pkg::OP_ADD, 32'd0, 1'($urandom_range(0, 1)), 1'b1, 1'b1, 32'd0,
			$urandom, 5'd0);
		c.id = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 63)) : 32'($urandom);
		if ($urandom_range(0, 99) < 6) c.lim = 1'b0;
		if ($urandom_range(0, 99) < 6) c.hp = 1'b0;
		pick = $urandom_range(0, 99);
		// narrow price band so levels gather several orders
		if (pick < 70) c.px = 32'd1000 + $urandom_range(0, 20);
		else if (pick < 88) c.px = $urandom;
		else c.px = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
		if ($urandom_range(0, 9) == 0) c.qty = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
		c.lv = 5'($urandom);
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 45) c = rand_add();
		else if (pick < 75) begin
			c = mk(lob_pkg::OP_CANCEL, 32'd0, 1'($urandom), 1'($urandom), 1'($urandom),
				$urandom, $urandom, 5'($urandom));
			c.id = ($urandom_range(0, 9) < 7) ? resting_id() : 32'($urandom_range(0, 63));
		end else if (pick < 95) begin
			c = mk(lob_pkg::OP_SNAP, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
				$urandom, $urandom, 5'd0);
			c.lv = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 4));
		end else
			c = mk(OP_NONE, $urandom, 1'($urandom), 1'($urandom), 1'($urandom),
				$urandom, $urandom, 5'($urandom));
		return c;
	endfunction

	initial begin
		cmd_t        directed[$];
		int          phase_pct[4];
		logic [31:0] fill_id;
		phase_pct = '{0, 52, 0, 19};
		fill_id = 32'h4000_0000;

		arst_n          <= 1'b0;
		start           <= 1'b0;
		operation       <= lob_pkg::OP_ADD;
		order_ref       <= '0;
		is_buy          <= 1'b0;
		is_limit        <= 1'b0;
		has_price       <= 1'b0;
		price           <= '0;
		quantity        <= '0;
		snapshot_levels <= 5'd1;
		for (int i = 0; i < SLOTS; i++) begin
			book_used[i] = 1'b0;
			book_id[i] = '0;
			book_buy[i] = 1'b0;
			book_px[i] = '0;
			book_qty[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty-book rows are typed in, the rest are predicted
		directed = '{
			mk_typed(mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
				lob_pkg::KIND_MARKER, lob_pkg::ST_OK),
			mk_typed(mk(lob_pkg::OP_CANCEL, 32'd5, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
				lob_pkg::KIND_BOOK, lob_pkg::ST_NOT_FOUND),
			mk_typed(mk(lob_pkg::OP_ADD, 32'd9, 1'b1, 1'b0, 1'b1, 32'd50, 32'd1, 5'd0),
				lob_pkg::KIND_BOOK, lob_pkg::ST_NOT_LIMIT),
			mk_typed(mk(lob_pkg::OP_ADD, 32'd9, 1'b1, 1'b1, 1'b0, 32'd50, 32'd1, 5'd0),
				lob_pkg::KIND_BOOK, lob_pkg::ST_NO_PRICE),
			mk_typed(mk(lob_pkg::OP_ADD, 32'd9, 1'b0, 1'b0, 1'b0, 32'd50, 32'd1, 5'd0),
				lob_pkg::KIND_BOOK, lob_pkg::ST_NOT_LIMIT),
			mk(lob_pkg::OP_ADD, 32'd1, 1'b1, 1'b1, 1'b1, 32'h0, 32'hFFFF_FFFF, 5'd0),
			mk(lob_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 5'd0),
			mk(lob_pkg::OP_ADD, 32'd2, 1'b1, 1'b1, 1'b1, 32'd100, 32'd7, 5'd0),
			mk(lob_pkg::OP_ADD, 32'd3, 1'b1, 1'b1, 1'b1, 32'd100, 32'hFFFF_FFFF, 5'd0),
			mk(lob_pkg::OP_ADD, 32'd4, 1'b0, 1'b1, 1'b1, 32'd101, 32'd11, 5'd0),
			mk(lob_pkg::OP_ADD, 32'd0, 1'b0, 1'b1, 1'b1, 32'd99, 32'd3, 5'd0),
			mk(lob_pkg::OP_ADD, 32'd2, 1'b0, 1'b1, 1'b1, 32'd200, 32'd5, 5'd0),
			mk(OP_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31),
			mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd1),
			mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd16),
			mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd31),
			mk(lob_pkg::OP_CANCEL, 32'd2, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
			mk(lob_pkg::OP_CANCEL, 32'd2, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
			mk(lob_pkg::OP_CANCEL, 32'd1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
			mk(lob_pkg::OP_CANCEL, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd0),
			mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd5)
		};
		foreach (directed[k]) issue(directed[k]);

		// random traffic, idling changing phase every stretch
		for (int n = 0; n < 40; n++) begin
			idle_pct = phase_pct[(n / 10) % 4];
			issue(rand_cmd());
		end

		// let the block drain completely before the book fill
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);

		// fill every slot with valid adds, then push past full
		idle_pct = 0;
		while (live_orders() < SLOTS) begin
			cmd_t c;
			c = rand_add();
			c.lim = 1'b1;
			c.hp = 1'b1;
			c.id = fill_id;
			fill_id = fill_id + 32'd1;
			issue(c);
		end
		for (int n = 0; n < 4; n++) begin
			cmd_t c;
			c = rand_add();
			c.lim = 1'b1;
			c.hp = 1'b1;
			c.id = $urandom | 32'h8000_0000;
			issue(c);
		end
		issue(mk(lob_pkg::OP_SNAP, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 5'd16));

		// thin the book down with cancels and mixed traffic
		idle_pct = 19;
		for (int n = 0; n < 20; n++) begin
			cmd_t c;
			c = mk(lob_pkg::OP_CANCEL, resting_id(), 1'($urandom), 1'($urandom),
				1'($urandom), $urandom, $urandom, 5'd0);
			issue((n % 3 == 0) ? rand_cmd() : c);
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("limit_order_book_levels_test: done, clean");
		else
			$display("limit_order_book_levels_test: done, errors");
		$finish;
	end

endmodule
